/* rtl/mps_pkg.sv */
package mps_pkg;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int POS_OUT_W        = 10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_MED_HI,
		ST_MED_LO,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RD_TAIL,
		RD_NEXT,
		RD_MID,
		RD_MIDM1
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    drop;
		logic    shift;
		logic    place;
		logic    cap_hi;
		logic    emit;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic move;
		logic last;
		logic ovf;
		logic out_free;
	} sts_t;

endpackage

/* rtl/mps_ctrl.sv */
module mps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_item,
	input  mps_pkg::sts_t  sts,
	output logic           in_stall,
	output mps_pkg::cmd_t  cmd
);

	mps_pkg::state_t state_q;
	mps_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mps_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sts.full) begin
						state_d = last_item ? mps_pkg::ST_MED_HI : mps_pkg::ST_IDLE;
					end else begin
						state_d = mps_pkg::ST_SHIFT;
					end
				end
			end
			mps_pkg::ST_SHIFT: begin
				if (!sts.move) begin
					state_d = sts.last ? mps_pkg::ST_MED_HI : mps_pkg::ST_IDLE;
				end
			end
			mps_pkg::ST_MED_HI: begin
				state_d = mps_pkg::ST_MED_LO;
			end
			mps_pkg::ST_MED_LO: begin
				state_d = mps_pkg::ST_EMIT;
			end
			mps_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					state_d = mps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mps_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = mps_pkg::RD_TAIL;
		in_stall   = 1'b1;
		unique case (state_q)
			mps_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
				cmd.drop = in_valid && sts.full;
			end
			mps_pkg::ST_SHIFT: begin
				cmd.rd_sel = mps_pkg::RD_NEXT;
				cmd.shift  = sts.move;
				cmd.place  = !sts.move;
			end
			mps_pkg::ST_MED_HI: begin
				cmd.rd_sel = mps_pkg::RD_MID;
			end
			mps_pkg::ST_MED_LO: begin
				cmd.rd_sel = mps_pkg::RD_MIDM1;
				cmd.cap_hi = 1'b1;
			end
			mps_pkg::ST_EMIT: begin
				cmd.rd_sel = mps_pkg::RD_MIDM1;
				cmd.emit   = sts.out_free;
			end
			default: begin
				cmd.rd_sel = mps_pkg::RD_TAIL;
			end
		endcase
	end

endmodule

/* rtl/mps_dp.sv */
module mps_dp #(
	parameter int MAX_ELEMENTS = mps_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_WIDTH  = mps_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] sample_value,
	input  logic                          last_item,
	input  mps_pkg::cmd_t                 cmd,
	input  logic                          out_stall,
	output mps_pkg::sts_t                 sts,
	output logic                          out_valid,
	output logic [mps_pkg::POS_OUT_W-1:0] lower_position,
	output logic [mps_pkg::POS_OUT_W-1:0] upper_position,
	output logic                          overflow
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int PW = mps_pkg::POS_OUT_W;

	logic signed [VALUE_WIDTH-1:0] val_mem [MAX_ELEMENTS];
	logic [AW-1:0]                 pos_mem [MAX_ELEMENTS];

	logic signed [VALUE_WIDTH-1:0] val_rd_q;
	logic [AW-1:0]                 pos_rd_q;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic                          last_q;
	logic [CW-1:0]                 j_q;
	logic [CW-1:0]                 count_q;
	logic                          ovf_q;
	logic [AW-1:0]                 hi_q;
	logic                          out_valid_q;
	logic [PW-1:0]                 lower_q;
	logic [PW-1:0]                 upper_q;
	logic                          overflow_q;

	logic [CW-1:0]                 tail_c;
	logic [CW-1:0]                 next_c;
	logic [CW-1:0]                 mid_c;
	logic [CW-1:0]                 midm1_c;
	logic [AW-1:0]                 raddr;
	logic                          we;
	logic [AW-1:0]                 waddr;
	logic signed [VALUE_WIDTH-1:0] wval;
	logic [AW-1:0]                 wpos;
	logic [AW-1:0]                 lo_pos;

	assign tail_c  = count_q - CW'(1);
	assign next_c  = j_q - CW'(2);
	assign mid_c   = count_q >> 1;
	assign midm1_c = mid_c - CW'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			mps_pkg::RD_TAIL:  raddr = tail_c[AW-1:0];
			mps_pkg::RD_NEXT:  raddr = next_c[AW-1:0];
			mps_pkg::RD_MID:   raddr = mid_c[AW-1:0];
			mps_pkg::RD_MIDM1: raddr = midm1_c[AW-1:0];
			default:           raddr = tail_c[AW-1:0];
		endcase
	end

	assign we    = cmd.shift || cmd.place;
	assign waddr = j_q[AW-1:0];
	assign wval  = cmd.shift ? val_rd_q : key_q;
	assign wpos  = cmd.shift ? pos_rd_q : count_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			val_mem[waddr] <= wval;
			pos_mem[waddr] <= wpos;
		end
		val_rd_q <= val_mem[raddr];
		pos_rd_q <= pos_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= sample_value;
			last_q <= last_item;
		end
		if (cmd.cap_hi) begin
			hi_q <= pos_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				j_q <= count_q;
			end else if (cmd.shift) begin
				j_q <= j_q - CW'(1);
			end
			if (cmd.emit) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (cmd.place) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.drop) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign lo_pos = count_q[0] ? hi_q : pos_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			lower_q    <= ovf_q ? '0 : PW'(lo_pos);
			upper_q    <= ovf_q ? '0 : PW'(hi_q);
			overflow_q <= ovf_q;
		end
	end

	assign sts.full     = (count_q == CW'(MAX_ELEMENTS));
	assign sts.empty    = (count_q == '0);
	assign sts.move     = (j_q != '0) && (val_rd_q > key_q);
	assign sts.last     = last_q;
	assign sts.ovf      = ovf_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign lower_position = lower_q;
	assign upper_position = upper_q;
	assign overflow       = overflow_q;

endmodule

/* rtl/median_position_select.sv */
// channel  direction  handshake               payload
// in       sink       in_valid / in_stall     sample_value, last_item
// out      source     out_valid / out_stall   lower_position, upper_position, overflow
//
// An item is loaded, then each stored entry greater than it (0 to count) is moved
// up one place, one entry per cycle through the sorted store's read and write ports, and
// the item is written in the gap. A marked item then reads the middle entries for the
// result; an item that meets a full store is dropped and flags overflow. Reset clears the
// count, flags and controller; the store is not cleared. A waiting result does not block
// input; a second result waits while the first is stalled, and input stalls meanwhile.
module median_position_select #(
	parameter int MAX_ELEMENTS = mps_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_WIDTH  = mps_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] sample_value,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mps_pkg::POS_OUT_W-1:0] lower_position,
	output logic [mps_pkg::POS_OUT_W-1:0] upper_position,
	output logic                          overflow
);

	mps_pkg::cmd_t cmd;
	mps_pkg::sts_t sts;

	mps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_item (last_item),
		.sts       (sts),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	mps_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_WIDTH  (VALUE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_value   (sample_value),
		.last_item      (last_item),
		.cmd            (cmd),
		.out_stall      (out_stall),
		.sts            (sts),
		.out_valid      (out_valid),
		.lower_position (lower_position),
		.upper_position (upper_position),
		.overflow       (overflow)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || !out_stall))
		else $error("result loaded over an untaken transaction");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (sts.empty && !sts.ovf && out_valid))
		else $error("sequence state not cleared after result");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sts.full) |=> sts.ovf)
		else $error("item at full store did not flag overflow");

endmodule
